@@ rtl/core/btlv_pkg.sv @@
// Shared types and constants for the BER-TLV header parser.
// No dependencies; imported by every module of the block, not by the interfaces.
`timescale 1ns / 1ps

package btlv_pkg;

  // largest long-form length byte count the block accepts
  localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

  // tag and length encoding constants
  localparam logic [4:0] TAG_MULTI_MARK = 5'h1F;
  localparam int unsigned LONG_FORM_BIT = 7;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_TAG_LONG  = 3'd2,
    ST_LEN_LONG  = 3'd3,
    ST_OVERRUN   = 3'd4
  } status_t;

  // one input item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_req;
    logic [31:0] buffer_size;
  } btlv_item_t;

  // one result item
  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] value_length;
    logic [2:0]  header_length;
    status_t     status;
  } btlv_result_t;

endpackage

@@ rtl/core/btlv_in_if.sv @@
// Input channel of the BER-TLV header parser: valid/ready plus one byte item.
// Depends on nothing but the port widths of the work item fields.
`timescale 1ns / 1ps

interface btlv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        start_req;
  logic [31:0] buffer_size;

  modport source (output valid, output data_byte, output start_req, output buffer_size,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input buffer_size,
                  output ready);
endinterface

@@ rtl/core/btlv_out_if.sv @@
// Result channel of the BER-TLV header parser: valid/ready plus decoded header.
// Depends on nothing but the port widths of the result fields.
`timescale 1ns / 1ps

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tag;
  logic [31:0] value_length;
  logic [2:0]  header_length;
  logic [2:0]  status;

  modport source (output valid, output tag, output value_length, output header_length,
                  output status, input ready);
  modport sink   (input valid, input tag, input value_length, input header_length,
                  input status, output ready);
endinterface

@@ rtl/core/btlv_step.sv @@
// Parser state and per-byte decode step of the BER-TLV header parser.
// Depends on btlv_pkg for the item, result and status types.
`timescale 1ns / 1ps

module btlv_step #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  btlv_pkg::btlv_item_t  item,
  output logic                  res_valid,
  output btlv_pkg::btlv_result_t res
);
  import btlv_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TAG2 = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_LENX = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [31:0] avail_r, avail_nxt;

  logic [6:0]  len_cnt;
  logic [2:0]  hc_inc;
  logic        short_buf;
  logic        overrun;
  logic [32:0] need;

  assign len_cnt   = item.data_byte[6:0];
  assign hc_inc    = hc_r + 3'd1;
  // another header byte is needed but the buffer is already used up
  assign short_buf = ({29'd0, hc_inc} >= avail_r);
  assign need      = {1'b0, len_nxt} + {30'd0, hc_nxt};
  assign overrun   = (need > {1'b0, avail_r});

  // next state and result for the byte in hand
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    hc_nxt    = hc_r;
    avail_nxt = avail_r;
    res_valid = 1'b0;
    res       = '0;
    res.status = ST_OK;

    if (item.start_req) begin
      avail_nxt = item.buffer_size;
      tag_nxt   = {8'd0, item.data_byte};
      len_nxt   = '0;
      left_nxt  = '0;
      hc_nxt    = 3'd1;
      phase_nxt = (item.data_byte[4:0] == TAG_MULTI_MARK) ? PH_TAG2 : PH_LEN;
      // start byte alone already uses up the buffer
      if (item.buffer_size <= 32'd1) begin
        res_valid  = 1'b1;
        res.status = ST_TRUNCATED;
        phase_nxt  = PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        PH_TAG2: begin
          hc_nxt = hc_inc;
          if (item.data_byte[LONG_FORM_BIT]) begin
            res_valid  = 1'b1;
            res.status = ST_TAG_LONG;
            phase_nxt  = PH_IDLE;
          end else begin
            tag_nxt   = {tag_r[7:0], item.data_byte};
            phase_nxt = PH_LEN;
            if (short_buf) begin
              res_valid  = 1'b1;
              res.status = ST_TRUNCATED;
              phase_nxt  = PH_IDLE;
            end
          end
        end
        PH_LEN: begin
          hc_nxt = hc_inc;
          if (item.data_byte[LONG_FORM_BIT]) begin
            priority if (len_cnt > 7'(MAX_LENGTH_BYTES)) begin
              res_valid  = 1'b1;
              res.status = ST_LEN_LONG;
              phase_nxt  = PH_IDLE;
            end else if (len_cnt == 7'd0) begin
              // long form with no length bytes: zero length, header done
              len_nxt    = '0;
              res_valid  = 1'b1;
              res.tag    = tag_r;
              res.value_length  = 32'd0;
              res.header_length = hc_inc;
              res.status = overrun ? ST_OVERRUN : ST_OK;
              phase_nxt  = PH_IDLE;
            end else begin
              left_nxt  = len_cnt[2:0];
              phase_nxt = PH_LENX;
              if (short_buf) begin
                res_valid  = 1'b1;
                res.status = ST_TRUNCATED;
                phase_nxt  = PH_IDLE;
              end
            end
          end else begin
            // short form length
            len_nxt    = {24'd0, item.data_byte};
            res_valid  = 1'b1;
            res.tag    = tag_r;
            res.value_length  = {24'd0, item.data_byte};
            res.header_length = hc_inc;
            res.status = overrun ? ST_OVERRUN : ST_OK;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_LENX: begin
          hc_nxt   = hc_inc;
          len_nxt  = {len_r[23:0], item.data_byte};
          left_nxt = left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            res_valid  = 1'b1;
            res.tag    = tag_r;
            res.value_length  = len_nxt;
            res.header_length = hc_inc;
            res.status = overrun ? ST_OVERRUN : ST_OK;
            phase_nxt  = PH_IDLE;
          end else if (short_buf) begin
            res_valid  = 1'b1;
            res.status = ST_TRUNCATED;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_IDLE: begin
          // bytes outside a header are dropped
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tag_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      hc_r    <= '0;
      avail_r <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      hc_r    <= hc_nxt;
      avail_r <= avail_nxt;
    end
  end

endmodule

@@ rtl/core/ber_tlv_header_parser.sv @@
// Top level of the BER-TLV header parser: input register, decode step, result register.
// Depends on btlv_pkg, btlv_in_if, btlv_out_if and btlv_step.
`timescale 1ns / 1ps

// Usage
// - in_item carries one byte of a BER-TLV object per item; start_req marks the
//   first byte of an object and samples buffer_size (bytes available from there).
// - out_item gives one result per object: tag, value_length, header_length and
//   status, either when the header completes or as soon as an error is known.
//   Bytes after that result are dropped until the next start byte.
// - Path: the byte that finishes the header is held in the input register,
//   decoded combinationally, and its result is registered in the result
//   register, which drives out_item.
// - Throughput: one byte per cycle unless out_item stalls; every stage is a
//   single register with a one-byte decode between them.
// - Stall: when out_item.ready is low with a result waiting, the pipeline
//   holds; in_item.ready stays high until the input register is also full.
// - Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for a start byte.
module ber_tlv_header_parser #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  btlv_in_if.sink     in_item,
  btlv_out_if.source  out_item
);
  import btlv_pkg::*;

  logic         s1_valid_r;
  btlv_item_t   s1_item_r;
  logic         out_valid_r;
  btlv_result_t out_res_r;

  logic         adv;
  logic         step_en;
  logic         step_res_valid;
  btlv_result_t step_res;
  logic         in_fire;

  // pipeline moves when the result register is free or being taken
  assign adv          = !out_valid_r || out_item.ready;
  assign in_item.ready = !s1_valid_r || adv;
  assign in_fire      = in_item.valid && in_item.ready;
  assign step_en      = s1_valid_r && adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte   <= in_item.data_byte;
      s1_item_r.start_req   <= in_item.start_req;
      s1_item_r.buffer_size <= in_item.buffer_size;
    end
  end

  // decode step
  btlv_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (step_en),
    .item      (s1_item_r),
    .res_valid (step_res_valid),
    .res       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step_en && step_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && step_res_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.tag           = out_res_r.tag;
  assign out_item.value_length  = out_res_r.value_length;
  assign out_item.header_length = out_res_r.header_length;
  assign out_item.status        = out_res_r.status;

  // error results carry no decoded header
  a_err_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == ST_TRUNCATED || out_res_r.status == ST_TAG_LONG ||
                    out_res_r.status == ST_LEN_LONG)
    |-> (out_res_r.tag == 16'd0 && out_res_r.value_length == 32'd0 &&
         out_res_r.header_length == 3'd0))
    else $error("error result with nonzero header fields");

  // a complete header spans at least a tag byte and a length byte
  a_hdr_len_min : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == ST_OK || out_res_r.status == ST_OVERRUN)
    |-> out_res_r.header_length >= 3'd2)
    else $error("complete header shorter than two bytes");

  // a held byte is not lost while the result side stalls
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register dropped a byte during stall");

  // a result register that is full and stalled keeps its result
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item.ready |=> out_valid_r && $stable(out_res_r))
    else $error("result register changed during stall");

endmodule
